// ===== rtl/core/pemm_pkg.sv =====
// Shared widths, register indexes and types for the polynomial evaluator.
// No dependencies; used by every module of the block.
`default_nettype none

package pemm_pkg;

  localparam int XW       = 8;   // x_value
  localparam int CW       = 16;  // coefficients, config data
  localparam int DEGW     = 3;   // degree register
  localparam int YW       = 61;  // y_value, min_seen, y_span
  localparam int MAXW     = 60;  // max_seen
  localparam int IDXW     = 3;   // config register index

  localparam int MAX_DEGREE_DEF = 6;

  localparam logic [IDXW-1:0] REG_DEGREE = 3'd0;
  localparam logic [IDXW-1:0] REG_COEF0  = 3'd1;

  typedef struct packed {
    logic valid;
    logic restart;
  } pemm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/polynomial_eval_min_max.sv =====
// Top level of the polynomial evaluator with running extremes.
// Depends on pemm_pkg, pemm_cell and pemm_track.
//
// Usage:
//   Input channel (in_valid/in_stall) carries x_value and restart; the output
//   channel (out_valid/out_stall) carries y_value, max_seen, min_seen, y_span.
//   Configuration is written through wr_en/wr_index/wr_data; the user must
//   write it only while idle, as the block itself does not enforce this.
//   Index 0 is degree, indexes 1..7 are coef_0..coef_6. An item passes
//   through a row of MAX_DEGREE+1 Horner cells, one multiply-add per cell per
//   cycle. On acceptance x_value and its token are registered (x_q, start),
//   then pass the cells in order and the tracker register. One item is in
//   flight at a time; the next item is taken on the same edge as the result
//   is taken. While the receiver stalls the result holds and in_stall stays
//   high. Reset (rst, synchronous) clears degree, coefficients and the max,
//   min and span trackers to zero and empties the block.
`default_nettype none

module polynomial_eval_min_max #(
  parameter int MAX_DEGREE = pemm_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [pemm_pkg::IDXW-1:0]         wr_index,
  input  wire logic [pemm_pkg::CW-1:0]           wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [pemm_pkg::XW-1:0]    x_value,
  input  wire logic                              restart,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [pemm_pkg::YW-1:0]         y_value,
  output logic [pemm_pkg::MAXW-1:0]              max_seen,
  output logic signed [pemm_pkg::YW-1:0]         min_seen,
  output logic [pemm_pkg::YW-1:0]                y_span
);

  localparam int NCELL = MAX_DEGREE + 1;

  logic [pemm_pkg::DEGW-1:0]         degree;
  logic signed [pemm_pkg::CW-1:0]    coef [0:MAX_DEGREE];
  logic [pemm_pkg::DEGW-1:0]         deg_eff;

  logic                              busy;
  logic                              start;
  logic                              restart_q;
  logic signed [pemm_pkg::XW-1:0]    x_q;
  logic                              accept;
  logic                              out_take;

  logic                              valid_chain [0:NCELL];
  logic signed [pemm_pkg::YW-1:0]    acc_chain   [0:NCELL];
  logic signed [pemm_pkg::CW-1:0]    coef_sel    [0:NCELL-1];

  pemm_pkg::pemm_ctl_t               trk_ctl;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        coef[k] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index == pemm_pkg::REG_DEGREE) begin
        degree <= wr_data[pemm_pkg::DEGW-1:0];
      end
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        if (wr_index == pemm_pkg::REG_COEF0 + pemm_pkg::IDXW'(k)) begin
          coef[k] <= signed'(wr_data);
        end
      end
    end
  end

  assign deg_eff = (degree > pemm_pkg::DEGW'(MAX_DEGREE)) ?
                   pemm_pkg::DEGW'(MAX_DEGREE) : degree;

  // input handshake
  assign out_take = out_valid && !out_stall;
  assign in_stall = busy && !out_take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (out_take) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_q       <= x_value;
      restart_q <= restart;
    end
  end

  // row of Horner cells, highest power first; powers above degree add zero
  assign valid_chain[0] = start;
  assign acc_chain[0]   = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    assign coef_sel[k] = (pemm_pkg::DEGW'(MAX_DEGREE - k) <= deg_eff) ?
                         coef[MAX_DEGREE - k] : '0;

    pemm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_chain[k]),
      .acc_in    (acc_chain[k]),
      .x_in      (x_q),
      .coef      (coef_sel[k]),
      .valid_out (valid_chain[k+1]),
      .acc_out   (acc_chain[k+1])
    );
  end

  assign trk_ctl.valid   = valid_chain[NCELL];
  assign trk_ctl.restart = restart_q;

  pemm_track u_track (
    .clk       (clk),
    .rst       (rst),
    .ctl       (trk_ctl),
    .y_in      (acc_chain[NCELL]),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .y_value   (y_value),
    .max_seen  (max_seen),
    .min_seen  (min_seen),
    .y_span    (y_span)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pemm_cell.sv =====
// One Horner step: acc_out = acc_in * x + coef, registered, with its token.
// Depends on pemm_pkg.
`default_nettype none

module pemm_cell (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            valid_in,
  input  wire logic signed [pemm_pkg::YW-1:0]  acc_in,
  input  wire logic signed [pemm_pkg::XW-1:0]  x_in,
  input  wire logic signed [pemm_pkg::CW-1:0]  coef,
  output logic                                 valid_out,
  output logic signed [pemm_pkg::YW-1:0]       acc_out
);

  logic signed [pemm_pkg::YW+pemm_pkg::XW-1:0] prod;
  logic [pemm_pkg::YW-1:0]                     sum;

  assign prod = acc_in * x_in;
  assign sum  = prod[pemm_pkg::YW-1:0]
              + {{(pemm_pkg::YW-pemm_pkg::CW){coef[pemm_pkg::CW-1]}}, coef};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in) begin
      acc_out <= signed'(sum);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pemm_track.sv =====
// Running max/min/span trackers and the result register.
// Depends on pemm_pkg.
`default_nettype none

module pemm_track (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pemm_pkg::pemm_ctl_t             ctl,
  input  wire logic signed [pemm_pkg::YW-1:0]  y_in,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic signed [pemm_pkg::YW-1:0]       y_value,
  output logic [pemm_pkg::MAXW-1:0]            max_seen,
  output logic signed [pemm_pkg::YW-1:0]       min_seen,
  output logic [pemm_pkg::YW-1:0]              y_span
);

  logic [pemm_pkg::MAXW-1:0]      base_max;
  logic signed [pemm_pkg::YW-1:0] base_min;
  logic [pemm_pkg::YW-1:0]        base_span;
  logic                           gt;
  logic                           lt;
  logic [pemm_pkg::YW-1:0]        span_hi;
  logic [pemm_pkg::YW-1:0]        span_lo;

  assign base_max  = ctl.restart ? '0 : max_seen;
  assign base_min  = ctl.restart ? '0 : min_seen;
  assign base_span = ctl.restart ? '0 : y_span;

  assign gt = y_in > signed'({1'b0, base_max});
  assign lt = y_in < base_min;

  // new extreme on one side: span measured from y to the other extreme
  assign span_hi = y_in - base_min;
  assign span_lo = {1'b0, base_max} - y_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      max_seen  <= '0;
      min_seen  <= '0;
      y_span    <= '0;
    end else begin
      if (ctl.valid) begin
        out_valid <= 1'b1;
        max_seen  <= gt ? y_in[pemm_pkg::MAXW-1:0] : base_max;
        min_seen  <= lt ? y_in : base_min;
        y_span    <= gt ? span_hi : (lt ? span_lo : base_span);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      y_value <= y_in;
    end
  end

endmodule

`default_nettype wire
